// ----- rtl/core/cbfs_pkg.sv -----
// Shared constants, request and status codes, and controller/datapath link types.
`timescale 1ns / 1ps

package cbfs_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int ELEM_W = 8;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);

  // Field widths fixed by the request and result formats
  localparam int REQ_W     = 3;
  localparam int OFF_W     = 5;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MAX  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MIN  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_req;
    logic push;
    logic set_full;
    logic set_empty;
    logic pop;
    logic idx_init;
    logic idx_wrap;
    logic idx_read;
    logic scan_init;
    logic scan_read;
    logic load_data;
    logic emit;
  } cbfs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             empty;
    logic             push_ok;
    logic             idx_out;
    logic             scan_last;
    logic             out_free;
  } cbfs_sts_t;

endpackage

// ----- rtl/core/cbfs_req_if.sv -----
// Request channel: valid/ready handshake with the request fields.
`timescale 1ns / 1ps

interface cbfs_req_if;
  logic                                valid;
  logic                                ready;
  logic [cbfs_pkg::REQ_W-1:0]          req_type;
  logic [cbfs_pkg::ELEM_W-1:0]         push_data;
  logic signed [cbfs_pkg::OFF_W-1:0]   offset;

  modport source (output valid, output req_type, output push_data, output offset,
                  input ready);
  modport sink   (input valid, input req_type, input push_data, input offset,
                  output ready);
endinterface

// ----- rtl/core/cbfs_rsp_if.sv -----
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface cbfs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cbfs_pkg::ELEM_W-1:0]   data;
  logic [cbfs_pkg::STAT_W-1:0]   status;
  logic [cbfs_pkg::CW-1:0]       occupancy;
  logic                          is_full;
  logic                          is_empty;

  modport source (output valid, output data, output status, output occupancy,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input data, input status, input occupancy,
                  input is_full, input is_empty, output ready);
endinterface

// ----- rtl/core/cbfs_ctrl.sv -----
// Controller state machine: sequences push, pop, read, and scan requests.
`timescale 1ns / 1ps

module cbfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cbfs_pkg::cbfs_sts_t  sts,
  output cbfs_pkg::cbfs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WRAP,
    S_LOAD,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.req_type)
          cbfs_pkg::REQ_PUSH: begin
            if (sts.push_ok) cmd.push = 1'b1;
            else cmd.set_full = 1'b1;
            state_next = S_DONE;
          end
          cbfs_pkg::REQ_POP: begin
            if (sts.empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_LOAD;
            end
          end
          cbfs_pkg::REQ_READ: begin
            cmd.idx_init = 1'b1;
            state_next   = S_WRAP;
          end
          cbfs_pkg::REQ_MAX, cbfs_pkg::REQ_MIN: begin
            if (sts.empty) begin
              state_next = S_DONE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_WRAP: begin
        // Fold the index by the capacity until it lands in range
        if (sts.idx_out) begin
          cmd.idx_wrap = 1'b1;
        end else begin
          cmd.idx_read = 1'b1;
          state_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_data = 1'b1;
        state_next    = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        if (sts.scan_last) state_next = S_LAST;
      end
      S_LAST: begin
        // Last read data is folded into the accumulator this cycle
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/cbfs_dp.sv -----
// Datapath: slot store, head and count, index folding, scan accumulator, result register.
`timescale 1ns / 1ps

module cbfs_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cbfs_pkg::REQ_W-1:0]        req_type,
  input  logic [cbfs_pkg::ELEM_W-1:0]       push_data,
  input  logic signed [cbfs_pkg::OFF_W-1:0] offset,
  input  logic                              cfg_we,
  input  logic [cbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbfs_pkg::CFG_W-1:0]        cfg_data,
  input  cbfs_pkg::cbfs_cmd_t               cmd,
  output cbfs_pkg::cbfs_sts_t               sts,
  cbfs_rsp_if.source                        rsp
);

  localparam int AW = cbfs_pkg::AW;
  localparam int CW = cbfs_pkg::CW;
  localparam int EW = cbfs_pkg::ELEM_W;
  localparam int SW = CW + 1;
  localparam int IW = SW + 1;

  // Configuration
  logic [cbfs_pkg::CAP_W-1:0] capacity;
  logic                       overwrite_mode;
  logic [CW-1:0]              cap_eff;

  // Queue state
  logic [AW-1:0] head;
  logic [CW-1:0] count;

  // Latched request
  logic [cbfs_pkg::REQ_W-1:0]        req_q;
  logic [EW-1:0]                     pdata_q;
  logic signed [cbfs_pkg::OFF_W-1:0] off_q;

  // Read index and scan walker
  logic signed [IW-1:0] idx;
  logic signed [IW-1:0] cap_s;
  logic                 idx_neg;
  logic                 idx_high;
  logic [AW-1:0]        scan_ptr;
  logic [CW-1:0]        scan_left;
  logic                 scan_rd_q;
  logic                 scan_first;

  // Result accumulation
  logic [EW-1:0]                 acc;
  logic [cbfs_pkg::STAT_W-1:0]   stat;
  logic                          out_valid;

  // Slot store with per-slot written bits
  logic [EW-1:0] mem [cbfs_pkg::DEPTH];
  logic          vld [cbfs_pkg::DEPTH];
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_mem;
  logic          rd_vld;
  logic [EW-1:0] rd_data;
  logic [AW-1:0] wr_addr;
  logic          push_over;

  // Reduce a sum that is below twice the capacity
  function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s, input logic [CW-1:0] c);
    logic [SW-1:0] r;
    r = (s >= SW'(c)) ? (s - SW'(c)) : s;
    return r[AW-1:0];
  endfunction

  // Clamp the capacity register into 1..DEPTH
  always_comb begin
    if (capacity == '0) cap_eff = CW'(1);
    else if (32'(capacity) > 32'(cbfs_pkg::DEPTH)) cap_eff = CW'(cbfs_pkg::DEPTH);
    else cap_eff = CW'(capacity);
  end

  assign cap_s     = IW'({1'b0, cap_eff});
  assign idx_neg   = idx[IW-1];
  assign idx_high  = !idx_neg && (idx >= cap_s);
  assign wr_addr   = wrap_sum(SW'(head) + SW'(count), cap_eff);
  assign push_over = (count == cap_eff);

  assign sts.req_type  = req_q;
  assign sts.empty     = (count == '0);
  assign sts.push_ok   = !push_over || overwrite_mode;
  assign sts.idx_out   = idx_neg || idx_high;
  assign sts.scan_last = (scan_left == CW'(1));
  assign sts.out_free  = !out_valid || rsp.ready;

  // Pick the read address for the current command
  always_comb begin
    if (cmd.idx_read) rd_addr = idx[AW-1:0];
    else if (cmd.scan_read) rd_addr = scan_ptr;
    else rd_addr = head;
  end

  assign rd_data = rd_vld ? rd_mem : '0;

  // Write and read the slot store
  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_addr] <= pdata_q;
    rd_mem <= mem[rd_addr];
  end

  // Track written slots; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbfs_pkg::DEPTH; i++) vld[i] <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.push) vld[wr_addr] <= 1'b1;
      rd_vld <= vld[rd_addr];
    end
  end

  // Configuration registers; a capacity write empties the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= cbfs_pkg::CAP_RESET;
      overwrite_mode <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == cbfs_pkg::CFG_CAPACITY) capacity <= cfg_data[cbfs_pkg::CAP_W-1:0];
      if (cfg_index == cbfs_pkg::CFG_OVERWRITE) overwrite_mode <= cfg_data[0];
    end
  end

  // Advance head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cfg_we && (cfg_index == cbfs_pkg::CFG_CAPACITY)) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      if (push_over) head <= wrap_sum(SW'(head) + SW'(1), cap_eff);
      else count <= count + CW'(1);
    end else if (cmd.pop) begin
      head  <= wrap_sum(SW'(head) + SW'(1), cap_eff);
      count <= count - CW'(1);
    end
  end

  // Latch request fields
  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req_q   <= req_type;
      pdata_q <= push_data;
      off_q   <= offset;
    end
  end

  // Form and fold the read index
  always_ff @(posedge clk) begin
    if (cmd.idx_init) begin
      idx <= IW'($signed({1'b0, head})) + IW'(off_q);
    end else if (cmd.idx_wrap) begin
      idx <= idx_neg ? (idx + cap_s) : (idx - cap_s);
    end
  end

  // Walk the stored entries for a scan
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_ptr  <= head;
      scan_left <= count;
    end else if (cmd.scan_read) begin
      scan_ptr  <= wrap_sum(SW'(scan_ptr) + SW'(1), cap_eff);
      scan_left <= scan_left - CW'(1);
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_rd_q  <= 1'b0;
      scan_first <= 1'b0;
    end else begin
      scan_rd_q <= cmd.scan_read;
      if (cmd.scan_init) scan_first <= 1'b1;
      else if (scan_rd_q) scan_first <= 1'b0;
    end
  end

  // Accumulate result data and status
  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      acc  <= '0;
      stat <= cbfs_pkg::ST_OK;
    end else begin
      if (cmd.set_full) stat <= cbfs_pkg::ST_FULL;
      if (cmd.set_empty) stat <= cbfs_pkg::ST_EMPTY;
      if (cmd.load_data) begin
        acc <= rd_data;
      end else if (scan_rd_q) begin
        if (scan_first) acc <= rd_data;
        else if ((req_q == cbfs_pkg::REQ_MAX) ? (rd_data > acc) : (rd_data < acc)) acc <= rd_data;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.data      <= acc;
      rsp.status    <= stat;
      rsp.occupancy <= count;
      rsp.is_full   <= (count == cap_eff);
      rsp.is_empty  <= (count == '0);
    end
  end

  assign rsp.valid = out_valid;

  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap_eff)
    else $error("entry count exceeds capacity");

  a_head_in_cap: assert property (@(posedge clk) disable iff (rst)
    CW'(head) < cap_eff)
    else $error("head outside capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || rsp.ready))
    else $error("result overwritten before it was taken");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.idx_read |-> (!idx_neg && !idx_high))
    else $error("read index not folded into range");

endmodule

// ----- rtl/core/circular_byte_fifo_with_stats.sv -----
// Top level: circular byte queue with overwrite mode and max/min scans.
// Each request yields one result. A read at offset folds head+offset into
// range by adding or subtracting the capacity one step at a time (no steps
// for in-range offsets); max/min scans of a non-empty queue walk the entries
// one per cycle over the single read port of the slot store. A new request is
// taken once the previous one is finished, even while its result still waits
// in the output register. Writing the capacity register empties the queue;
// the user must write configuration only while the block is idle; the block
// itself does not enforce this.
`timescale 1ns / 1ps

module circular_byte_fifo_with_stats (
  input  logic                               clk,
  input  logic                               rst,
  cbfs_req_if.sink                           req,
  cbfs_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [cbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbfs_pkg::CFG_W-1:0]         cfg_data
);

  cbfs_pkg::cbfs_cmd_t cmd;
  cbfs_pkg::cbfs_sts_t sts;
  logic                req_ready;

  assign req.ready = req_ready;

  cbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbfs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_type  (req.req_type),
    .push_data (req.push_data),
    .offset    (req.offset),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

// ----- tb/tb_circular_byte_fifo_with_stats.sv -----
// Self-checking bench for the circular byte queue: directed corners, random traffic, stalls.
`timescale 1ns / 1ps

module tb_circular_byte_fifo_with_stats;

  // Request codes the block does not know; they must leave the queue alone
  localparam logic [cbfs_pkg::REQ_W-1:0] REQ_NONE_FIRST = 3'd5;
  localparam logic [cbfs_pkg::REQ_W-1:0] REQ_NONE_LAST  = 3'd7;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 120;
  localparam int SEG_ITEMS     = 50;

  typedef struct packed {
    logic [cbfs_pkg::ELEM_W-1:0] data;
    logic [cbfs_pkg::STAT_W-1:0] status;
    logic [cbfs_pkg::CW-1:0]     occupancy;
    logic                        is_full;
    logic                        is_empty;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic                           cfg_we;
  logic [cbfs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cbfs_pkg::CFG_W-1:0]     cfg_data;

  cbfs_req_if req_ch ();
  cbfs_rsp_if rsp_ch ();

  circular_byte_fifo_with_stats dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the queue contents and registers
  logic [cbfs_pkg::ELEM_W-1:0] mirror_slots [cbfs_pkg::DEPTH];
  int                          mirror_head;
  int                          mirror_count;
  logic [cbfs_pkg::CAP_W-1:0]  mirror_cap;
  logic                        mirror_overwrite;

  queue_reply_t replies_due [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_rx = 1'b0;
  event hold_off_ev;

  always #4 clk = ~clk;

  // Apply one request to the mirror and return the reply it must produce
  function automatic queue_reply_t apply_request(
      input logic [cbfs_pkg::REQ_W-1:0]        kind,
      input logic [cbfs_pkg::ELEM_W-1:0]       byte_in,
      input logic signed [cbfs_pkg::OFF_W-1:0] off);
    queue_reply_t r;
    int cap;
    int t;
    int i;
    logic [cbfs_pkg::ELEM_W-1:0] v;
    r = '0;
    cap = (mirror_cap == 0) ? 1 :
          ((int'(mirror_cap) > cbfs_pkg::DEPTH) ? cbfs_pkg::DEPTH : int'(mirror_cap));
    if (mirror_head >= cap) mirror_head = mirror_head % cap;
    if (mirror_count > cap) mirror_count = cap;
    case (kind)
      cbfs_pkg::REQ_PUSH: begin
        if (mirror_count == cap && !mirror_overwrite) begin
          r.status = cbfs_pkg::ST_FULL;
        end else begin
          mirror_slots[(mirror_head + mirror_count) % cap] = byte_in;
          if (mirror_count == cap) mirror_head = (mirror_head + 1) % cap;
          else mirror_count++;
        end
      end
      cbfs_pkg::REQ_POP: begin
        if (mirror_count == 0) begin
          r.status = cbfs_pkg::ST_EMPTY;
        end else begin
          r.data = mirror_slots[mirror_head];
          mirror_head = (mirror_head + 1) % cap;
          mirror_count--;
        end
      end
      cbfs_pkg::REQ_READ: begin
        // Signed offset folds backwards for negative values
        t = (mirror_head + int'(off)) % cap;
        if (t < 0) t += cap;
        r.data = mirror_slots[t];
      end
      cbfs_pkg::REQ_MAX, cbfs_pkg::REQ_MIN: begin
        for (i = 0; i < mirror_count; i++) begin
          v = mirror_slots[(mirror_head + i) % cap];
          if (i == 0 || (kind == cbfs_pkg::REQ_MAX ? v > r.data : v < r.data)) r.data = v;
        end
      end
      default: ;
    endcase
    r.occupancy = cbfs_pkg::CW'(mirror_count);
    r.is_full   = (mirror_count == cap);
    r.is_empty  = (mirror_count == 0);
    return r;
  endfunction

  // Offer one request, wait for the handshake, record the reply it owes
  task automatic send_req(input logic [cbfs_pkg::REQ_W-1:0]        kind,
                          input logic [cbfs_pkg::ELEM_W-1:0]       byte_in,
                          input logic signed [cbfs_pkg::OFF_W-1:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.push_data <= byte_in;
    req_ch.offset    <= off;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    replies_due.push_back(apply_request(kind, byte_in, off));
  endtask

  // Drop valid and wait until every reply is back and the block is quiet
  task automatic settle_queue();
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the block must be idle
  task automatic write_reg(input logic [cbfs_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cbfs_pkg::CFG_W'(value);
    @(posedge clk);
    if (idx == cbfs_pkg::CFG_CAPACITY) begin
      mirror_cap   = cbfs_pkg::CAP_W'(value);
      mirror_head  = 0;
      mirror_count = 0;
    end else begin
      mirror_overwrite = value[0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [cbfs_pkg::ELEM_W-1:0] want,
                               input logic [cbfs_pkg::ELEM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check one reply against the oldest one owed
  task automatic check_reply();
    queue_reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: reply with none owed, expected nothing, actual data %0h status %0h",
               $time, rsp_ch.data, rsp_ch.status);
      mismatches++;
    end else begin
      want = replies_due.pop_front();
      compare_field("data", want.data, rsp_ch.data);
      compare_field("status", cbfs_pkg::ELEM_W'(want.status),
                    cbfs_pkg::ELEM_W'(rsp_ch.status));
      compare_field("occupancy", cbfs_pkg::ELEM_W'(want.occupancy),
                    cbfs_pkg::ELEM_W'(rsp_ch.occupancy));
      compare_field("is_full", cbfs_pkg::ELEM_W'(want.is_full),
                    cbfs_pkg::ELEM_W'(rsp_ch.is_full));
      compare_field("is_empty", cbfs_pkg::ELEM_W'(want.is_empty),
                    cbfs_pkg::ELEM_W'(rsp_ch.is_empty));
    end
  endtask

  // Receiver: sample replies, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_reply();
    rsp_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold the receiver off for a fixed stretch on request
  always begin
    @(hold_off_ev);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  function automatic logic [cbfs_pkg::REQ_W-1:0] pick_kind(input int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return cbfs_pkg::REQ_PUSH;
    roll = $urandom_range(99);
    if (roll < 45) return cbfs_pkg::REQ_POP;
    if (roll < 70) return cbfs_pkg::REQ_READ;
    if (roll < 83) return cbfs_pkg::REQ_MAX;
    if (roll < 96) return cbfs_pkg::REQ_MIN;
    return cbfs_pkg::REQ_W'($urandom_range(REQ_NONE_LAST, REQ_NONE_FIRST));
  endfunction

  // Empty queue at reset: pop, scans, reads of untouched slots, unknown code
  task automatic test_reset_state();
    send_req(cbfs_pkg::REQ_POP, 8'h00, 0);
    send_req(cbfs_pkg::REQ_MAX, 8'h00, 0);
    send_req(cbfs_pkg::REQ_MIN, 8'h00, 0);
    send_req(cbfs_pkg::REQ_READ, 8'h00, 15);
    send_req(cbfs_pkg::REQ_READ, 8'h00, -16);
    send_req(REQ_NONE_LAST, 8'hFF, -1);
    settle_queue();
  endtask

  // Fill a small queue, reject the extra push, scan and read with wrap
  task automatic test_fill_reject();
    write_reg(cbfs_pkg::CFG_CAPACITY, 3);
    send_req(cbfs_pkg::REQ_PUSH, 8'hFF, 0);
    send_req(cbfs_pkg::REQ_PUSH, 8'h00, 0);
    send_req(cbfs_pkg::REQ_PUSH, 8'h5A, 0);
    send_req(cbfs_pkg::REQ_PUSH, 8'h11, 0);
    send_req(cbfs_pkg::REQ_MAX, 8'h00, 0);
    send_req(cbfs_pkg::REQ_MIN, 8'h00, 0);
    send_req(cbfs_pkg::REQ_READ, 8'h00, -1);
    send_req(cbfs_pkg::REQ_READ, 8'h00, 4);
    settle_queue();
  endtask

  // Overwrite the oldest entry, then drain past empty
  task automatic test_overwrite();
    write_reg(cbfs_pkg::CFG_OVERWRITE, 1);
    send_req(cbfs_pkg::REQ_PUSH, 8'hA5, 0);
    repeat (4) send_req(cbfs_pkg::REQ_POP, 8'h00, 0);
    settle_queue();
  endtask

  // Capacity zero acts as a single slot
  task automatic test_tiny_capacity();
    write_reg(cbfs_pkg::CFG_CAPACITY, 0);
    send_req(cbfs_pkg::REQ_PUSH, 8'h3C, 0);
    send_req(cbfs_pkg::REQ_PUSH, 8'hC3, 0);
    send_req(cbfs_pkg::REQ_READ, 8'h00, 15);
    send_req(cbfs_pkg::REQ_READ, 8'h00, -15);
    settle_queue();
  endtask

  // Random traffic over four register settings, one of them an extreme capacity
  task automatic test_random_phase(input int tx_idle, input int rx_idle, input int edge_cap);
    int seg;
    int cap;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: cap = cbfs_pkg::DEPTH;
        1: cap = $urandom_range(8, 2);
        2: cap = edge_cap;
        default: cap = $urandom_range(31, 0);
      endcase
      write_reg(cbfs_pkg::CFG_CAPACITY, cap);
      write_reg(cbfs_pkg::CFG_OVERWRITE, $urandom_range(1));
      repeat (SEG_ITEMS) begin
        send_req(pick_kind($urandom_range(65, 35)), cbfs_pkg::ELEM_W'($urandom),
                 cbfs_pkg::OFF_W'($urandom));
      end
      settle_queue();
    end
  endtask

  // Stall the receiver while pushes keep coming so the block backs up
  task automatic test_backpressure();
    write_reg(cbfs_pkg::CFG_CAPACITY, cbfs_pkg::DEPTH);
    write_reg(cbfs_pkg::CFG_OVERWRITE, 0);
    -> hold_off_ev;
    repeat (12) send_req(cbfs_pkg::REQ_PUSH, cbfs_pkg::ELEM_W'($urandom), 0);
    send_req(cbfs_pkg::REQ_MAX, 8'h00, 0);
    send_req(cbfs_pkg::REQ_MIN, 8'h00, 0);
    settle_queue();
  endtask

  initial begin
    foreach (mirror_slots[i]) mirror_slots[i] = '0;
    mirror_head      = 0;
    mirror_count     = 0;
    mirror_cap       = cbfs_pkg::CAP_RESET;
    mirror_overwrite = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = cbfs_pkg::CFG_CAPACITY;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = cbfs_pkg::REQ_PUSH;
    req_ch.push_data = '0;
    req_ch.offset    = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_fill_reject();
    test_overwrite();
    test_tiny_capacity();
    test_random_phase(23, 67, 1);
    test_random_phase(67, 23, 0);
    test_backpressure();
    test_random_phase(0, 0, 31);

    settle_queue();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
